[hdl/lbha_pkg.sv]
`default_nettype none
package lbha_pkg;
   localparam int COORD_BITS = 12;
   localparam int NUM_SLOTS  = 18;
   localparam int SLOT_BITS  = 5;
   localparam int Q_BITS     = 21;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int DEN_BITS   = COORD_BITS + 1;
   localparam int NUM_BITS   = COORD_BITS + 1;
   localparam int QUO_BITS   = NUM_BITS + 16;
   localparam int STEP_BITS  = 5;

   localparam logic signed [Q_BITS-1:0] Q_MAX = 21'sd1048575;
   localparam logic signed [Q_BITS-1:0] Q_MIN = -21'sd1048576;
   localparam logic signed [Q_BITS-1:0] Q_ONE = 21'sd65536;
   localparam logic signed [Q_BITS-1:0] PITCH_OFFSET = 21'sd39322;
   localparam logic [15:0] THRESHOLD_RESET = 16'd13107;

   localparam logic [SLOT_BITS-1:0] SLOT_NONE = 5'd31;

   typedef enum logic [2:0] {
      DIV_LEFT  = 3'd0,
      DIV_RIGHT = 3'd1,
      DIV_PITCH = 3'd2,
      DIV_YAW   = 3'd3
   } div_sel_type;

   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [6:0] idx);
      logic [SLOT_BITS-1:0] s;
      s = SLOT_NONE;
      case (idx)
         7'd1:  s = 5'd0;
         7'd8:  s = 5'd1;
         7'd15: s = 5'd2;
         7'd21: s = 5'd3;
         7'd22: s = 5'd4;
         7'd30: s = 5'd5;
         default: begin
            if (idx >= 7'd36 && idx <= 7'd47) s = SLOT_BITS'(idx - 7'd30);
         end
      endcase
      return s;
   endfunction
endpackage
`default_nettype wire

[hdl/landmark_blink_and_head_angle.sv]
`default_nettype none
// A point without frame_end is stored as it is taken; a frame_end point starts an
// evaluation: one shared restoring divider runs four ratios in turn, each a setup
// step and then its quotient-bit steps, then a final step registers the result.
// Intake: one point per cycle while the block is idle; after a frame_end point
// the next point is taken only once the result has been accepted (rsp_stall low).
// Reset (synchronous): trackers cleared, minimum set to 0.2, count zero.
module landmark_blink_and_head_angle import lbha_pkg::*; (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  req_valid,
   output       logic                  req_stall,
   input  wire  logic [6:0]            req_point_index,
   input  wire  logic [11:0]           req_point_x,
   input  wire  logic [11:0]           req_point_y,
   input  wire  logic                  req_frame_end,
   output       logic                  rsp_valid,
   input  wire  logic                  rsp_stall,
   output       logic                  rsp_blink_event,
   output       logic signed [6:0]     rsp_yaw_angle,
   output       logic signed [4:0]     rsp_pitch_angle,
   output       logic [31:0]           rsp_blinks_so_far,
   input  wire  logic                  csr_write_enable,
   input  wire  logic [15:0]           csr_write_data
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_FINAL = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef logic signed [DIFF_BITS-1:0] diff_type;

   state_type state_ff, state_in;
   logic [COORD_BITS-1:0] px_ff [NUM_SLOTS];
   logic [COORD_BITS-1:0] py_ff [NUM_SLOTS];
   logic [15:0] thr_ff;
   logic signed [Q_BITS-1:0] max_before_ff, min_now_ff, max_after_ff;
   logic [31:0] total_ff;
   div_sel_type sel_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic [QUO_BITS-1:0] rem_ff, quo_ff, dvd_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic neg_ff, dz_ff, nz_ff;
   logic signed [Q_BITS-1:0] r_left_ff, r_right_ff, r_pitch_ff, r_yaw_ff;

   // slots: 0..5 = 1,8,15,21,22,30; 6+ = 36..47
   function automatic diff_type dx(input int a, input int b);
      return diff_type'({1'b0, px_ff[a]}) - diff_type'({1'b0, px_ff[b]});
   endfunction
   function automatic diff_type dy(input int a, input int b);
      return diff_type'({1'b0, py_ff[a]}) - diff_type'({1'b0, py_ff[b]});
   endfunction

   logic signed [DIFF_BITS:0] num_s, den_s;
   logic signed [DIFF_BITS+1:0] hsum;
   always_comb begin
      num_s = '0;
      den_s = '0;
      hsum  = '0;
      case (sel_ff)
         DIV_LEFT: begin
            hsum  = (DIFF_BITS+2)'(dy(11, 7)) + (DIFF_BITS+2)'(dy(10, 8));
            num_s = (DIFF_BITS+1)'(hsum / 2);
            if (num_s == 0) num_s = (DIFF_BITS+1)'(1);
            den_s = (DIFF_BITS+1)'(dx(9, 6));
         end
         DIV_RIGHT: begin
            hsum  = (DIFF_BITS+2)'(dy(17, 13)) + (DIFF_BITS+2)'(dy(16, 14));
            num_s = (DIFF_BITS+1)'(hsum / 2);
            if (num_s == 0) num_s = (DIFF_BITS+1)'(1);
            den_s = (DIFF_BITS+1)'(dx(15, 12));
         end
         DIV_PITCH: begin
            hsum  = (DIFF_BITS+2)'({1'b0, py_ff[3]}) + (DIFF_BITS+2)'({1'b0, py_ff[4]});
            num_s = (DIFF_BITS+1)'({1'b0, py_ff[5]}) - (DIFF_BITS+1)'(hsum >>> 1);
            den_s = (DIFF_BITS+1)'(dy(1, 5));
         end
         default: begin
            num_s = (DIFF_BITS+1)'(dx(5, 0));
            den_s = (DIFF_BITS+1)'(dx(2, 5));
         end
      endcase
   end

   // shared restoring divider step
   logic [QUO_BITS-1:0] trial;
   logic [QUO_BITS:0] sub;
   always_comb begin
      trial = {rem_ff[QUO_BITS-2:0], dvd_ff[QUO_BITS-1]};
      sub   = {1'b0, trial} - {{(QUO_BITS+1-DEN_BITS){1'b0}}, den_ff};
   end

   logic signed [Q_BITS-1:0] ratio;
   logic [QUO_BITS-1:0] qfin;
   always_comb begin
      qfin = sub[QUO_BITS] ? {quo_ff[QUO_BITS-2:0], 1'b0} : {quo_ff[QUO_BITS-2:0], 1'b1};
      if (dz_ff)
         ratio = nz_ff ? '0 : (neg_ff ? Q_MIN : Q_MAX);
      else if (!neg_ff)
         ratio = (qfin > QUO_BITS'(Q_MAX)) ? Q_MAX : Q_BITS'(qfin);
      else
         ratio = (qfin > QUO_BITS'(1048576)) ? Q_MIN : -Q_BITS'(qfin);
   end

   logic signed [Q_BITS:0] avg_sum;
   logic signed [Q_BITS-1:0] avg, nb, nn, na, thr_s;
   logic blink;
   logic signed [Q_BITS+7:0] pmul;
   logic signed [Q_BITS+7:0] pq;
   logic signed [Q_BITS+7:0] ymul, yq;
   logic signed [6:0] yaw;
   logic signed [4:0] pitch;
   always_comb begin
      avg_sum = (Q_BITS+1)'(r_left_ff) + (Q_BITS+1)'(r_right_ff);
      avg = Q_BITS'(avg_sum / 2);
      nb = (max_before_ff < avg) ? avg : max_before_ff;
      nn = (min_now_ff > avg) ? avg : min_now_ff;
      na = (max_after_ff < avg) ? avg : max_after_ff;
      thr_s = Q_BITS'({1'b0, thr_ff});
      blink = (nb > thr_s) && (nn <= thr_s) && (na > thr_s);
      pmul = ((Q_BITS+8)'(r_pitch_ff) - (Q_BITS+8)'(PITCH_OFFSET)) * (Q_BITS+8)'(75);
      pq = pmul / (Q_BITS+8)'(65536);
      if (pq > 15) pitch = 5'sd15;
      else if (pq < -15) pitch = -5'sd15;
      else pitch = 5'(pq);
      ymul = '0;
      yq = '0;
      if (r_yaw_ff < Q_ONE) begin
         ymul = ((Q_BITS+8)'(Q_ONE) - (Q_BITS+8)'(r_yaw_ff)) * (Q_BITS+8)'(72);
         yq = -(ymul / (Q_BITS+8)'(65536));
      end else if (r_yaw_ff > Q_ONE) begin
         // r * 90 / (9 * 65536) reduces to r * 10 / 65536
         ymul = (Q_BITS+8)'(r_yaw_ff) * (Q_BITS+8)'(10);
         yq = ymul / (Q_BITS+8)'(65536);
      end
      if (yq > 60) yaw = 7'sd60;
      else if (yq < -60) yaw = -7'sd60;
      else yaw = 7'(yq);
   end

   assign req_stall = (state_ff != ST_IDLE);
   wire take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (take && req_frame_end) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == STEP_BITS'(QUO_BITS-1))
               state_in = (sel_ff == DIV_YAW) ? ST_FINAL : ST_SETUP;
         end
         ST_FINAL: state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   logic [SLOT_BITS-1:0] slot;
   assign slot = slot_of(req_point_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff <= THRESHOLD_RESET;
         max_before_ff <= '0;
         min_now_ff <= Q_BITS'({1'b0, THRESHOLD_RESET});
         max_after_ff <= '0;
         total_ff <= '0;
         sel_ff <= DIV_LEFT;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) thr_ff <= csr_write_data;
         if (state_ff == ST_IDLE && state_in == ST_SETUP) sel_ff <= DIV_LEFT;
         if (state_ff == ST_DIV && state_in == ST_SETUP)
            sel_ff <= div_sel_type'(sel_ff + 3'd1);
         if (state_ff == ST_FINAL) begin
            rsp_valid <= 1'b1;
            if (blink) begin
               max_before_ff <= '0;
               min_now_ff <= thr_s;
               max_after_ff <= '0;
               total_ff <= total_ff + 32'd1;
            end else begin
               max_before_ff <= nb;
               min_now_ff <= nn;
               max_after_ff <= na;
            end
         end
         if (state_ff == ST_OUT && !rsp_stall) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && slot != SLOT_NONE) begin
         px_ff[slot] <= req_point_x[COORD_BITS-1:0];
         py_ff[slot] <= req_point_y[COORD_BITS-1:0];
      end
      if (state_ff == ST_SETUP) begin
         // zero divisor saturates toward the sign of the numerator
         neg_ff <= (den_s == 0) ? num_s[DIFF_BITS] : (num_s[DIFF_BITS] ^ den_s[DIFF_BITS]);
         dz_ff  <= (den_s == 0);
         nz_ff  <= (num_s == 0);
         dvd_ff <= {(num_s[DIFF_BITS] ? NUM_BITS'(-num_s) : NUM_BITS'(num_s)), 16'd0};
         den_ff <= den_s[DIFF_BITS] ? DEN_BITS'(-den_s) : DEN_BITS'(den_s);
         rem_ff <= '0;
         quo_ff <= '0;
         step_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= sub[QUO_BITS] ? trial : sub[QUO_BITS-1:0];
         quo_ff <= qfin;
         dvd_ff <= {dvd_ff[QUO_BITS-2:0], 1'b0};
         step_ff <= step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(QUO_BITS-1)) begin
            case (sel_ff)
               DIV_LEFT:  r_left_ff <= ratio;
               DIV_RIGHT: r_right_ff <= ratio;
               DIV_PITCH: r_pitch_ff <= ratio;
               default:   r_yaw_ff <= ratio;
            endcase
         end
      end
      if (state_ff == ST_FINAL) begin
         rsp_blink_event <= blink;
         rsp_yaw_angle <= yaw;
         rsp_pitch_angle <= pitch;
         rsp_blinks_so_far <= blink ? total_ff + 32'd1 : total_ff;
      end
   end

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while result pending");
   a_out_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_OUT)) else $error("result valid outside output state");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |=> (total_ff == $past(total_ff) + 32'($past(blink))))
      else $error("blink count slip");
endmodule
`default_nettype wire
